[hdl/nlp_pkg.sv]
// Shared types, constants and helper functions of the number literal parser.
// Depends on nothing; every other file of the block refers to it by scoped name.
`default_nettype none

package nlp_pkg;

  // Text length limit and the widths that follow from it
  localparam int TEXT_LEN_MAX = 4096;
  localparam int COUNT_W      = $clog2(TEXT_LEN_MAX + 1);
  localparam int CHAR_W       = 8;
  localparam int VALUE_W      = 64;
  localparam int DIGIT_W      = 5;
  // magnitude times sixteen plus a digit fits in four extra bits
  localparam int MAC_W        = VALUE_W + 4;

  // Digit value that means "not a hex digit"
  localparam logic [DIGIT_W-1:0] NOT_HEX = '1;

  // Characters the parser looks at
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UO    = 8'h4f;
  localparam logic [CHAR_W-1:0] CH_LO    = 8'h6f;
  localparam logic [CHAR_W-1:0] CH_UT    = 8'h54;
  localparam logic [CHAR_W-1:0] CH_LT    = 8'h74;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_NAN = 2'd1,
    ST_OVF = 2'd2
  } status_t;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_SIGN   = 5'b00010,
    PH_ZERO   = 5'b00100,
    PH_PREFIX = 5'b01000,
    PH_DIGITS = 5'b10000
  } phase_t;

  // Radix in force
  typedef enum logic [1:0] {
    RDX_2  = 2'd0,
    RDX_8  = 2'd1,
    RDX_10 = 2'd2,
    RDX_16 = 2'd3
  } radix_t;

  // One result transaction
  typedef struct packed {
    status_t                    status;
    logic signed [VALUE_W-1:0]  value;
    logic        [COUNT_W-1:0]  consumed;
  } result_t;

  // Value of a hex digit, NOT_HEX for any other character
  function automatic logic [DIGIT_W-1:0] hex_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = CH_NUL;
    if (c inside {[CH_0:CH_9]}) begin
      d = c - CH_0;
    end else if (c inside {[CH_LA:CH_LF]}) begin
      d = c - CH_LA + 8'd10;
    end else if (c inside {[CH_UA:CH_UF]}) begin
      d = c - CH_UA + 8'd10;
    end else begin
      d = {{(CHAR_W-DIGIT_W){1'b0}}, NOT_HEX};
    end
    return d[DIGIT_W-1:0];
  endfunction

  // Numeric value of a radix code
  function automatic logic [DIGIT_W-1:0] radix_value(input radix_t r);
    logic [DIGIT_W-1:0] v;
    case (r)
      RDX_2:   v = 5'd2;
      RDX_8:   v = 5'd8;
      RDX_10:  v = 5'd10;
      RDX_16:  v = 5'd16;
      default: v = 5'd10;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[hdl/nlp_channels.sv]
// Valid/ready channel interfaces for the character input and the result output.
// Depends on nlp_pkg for field widths and the status type.
`default_nettype none

interface nlp_in_if;
  logic                          valid;
  logic                          ready;
  logic [nlp_pkg::CHAR_W-1:0]    char_in;
  logic                          start_req;

  modport source (output valid, output char_in, output start_req, input ready);
  modport sink   (input valid, input char_in, input start_req, output ready);
endinterface

interface nlp_out_if;
  logic                                 valid;
  logic                                 ready;
  nlp_pkg::status_t                     status;
  logic signed [nlp_pkg::VALUE_W-1:0]   value;
  logic        [nlp_pkg::COUNT_W-1:0]   consumed;

  modport source (output valid, output status, output value, output consumed, input ready);
  modport sink   (input valid, input status, input value, input consumed, output ready);
endinterface

`default_nettype wire

[hdl/number_literal_parser_core.sv]
// Top level of the number literal parser: per-character state update and a
// two-entry result buffer. Depends on nlp_pkg and the channels in nlp_channels.sv.
`default_nettype none

// The parser takes one character per cycle while input is not held off and gives
// at most one result per literal: a literal opens with the character sent with
// start_req high, takes an optional sign, a decimal, octal (leading 0) or
// prefixed (0x, 0o, 0t) body, and closes at the first character that is not a
// digit of its radix, at end of text (character 0) or on overflow past 2^63-1. A
// character is taken in the cycle it is offered unless input is held off, and its
// result, if any, is registered into the result buffer; the rate of one character
// per cycle is set by the combinational shift-add of the 64-bit magnitude by the
// radix. Two result entries are buffered, so input is held off only while both
// wait to be taken. No clearing pass is needed after reset.
module number_literal_parser_core (
  input  wire           clk,
  input  wire           rst_n,
  nlp_in_if.sink        in_ch,
  nlp_out_if.source     out_ch
);

  // Parser state
  nlp_pkg::phase_t                    phase_r,  phase_nxt;
  logic                               neg_r,    neg_nxt;
  nlp_pkg::radix_t                    radix_r,  radix_nxt;
  logic [nlp_pkg::VALUE_W-1:0]        mag_r,    mag_nxt;
  logic [nlp_pkg::COUNT_W-1:0]        count_r,  count_nxt;
  logic [nlp_pkg::CHAR_W-1:0]         held_r,   held_nxt;

  // Result buffer: main entry drives the port, skid entry catches a stall
  nlp_pkg::result_t                   out_r,    out_nxt;
  logic                               out_vld_r, out_vld_nxt;
  nlp_pkg::result_t                   skid_r,   skid_nxt;
  logic                               skid_vld_r, skid_vld_nxt;

  logic                               in_acc;
  logic                               res_vld;
  nlp_pkg::result_t                   res;
  nlp_pkg::result_t                   fin_res;

  logic [nlp_pkg::CHAR_W-1:0]         c_eff;
  logic [nlp_pkg::DIGIT_W-1:0]        hex_d;
  logic                               hex_ok;
  logic [nlp_pkg::MAC_W-1:0]          mag_ext;
  logic [nlp_pkg::MAC_W-1:0]          mac;
  logic                               mac_ovf;
  logic                               digit_ok;

  // First-digit decode, shared by the start character and the one after a sign
  logic [nlp_pkg::CHAR_W-1:0]         fd_char;
  logic [nlp_pkg::COUNT_W-1:0]        fd_base;
  logic                               fd_is_dec;

  // Prefix decode
  logic                               pfx_known;
  nlp_pkg::radix_t                    pfx_radix;
  logic                               pfx_room;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !skid_vld_r;

  // Past the length limit every character reads as end of text
  assign c_eff  = (count_r >= nlp_pkg::COUNT_W'(nlp_pkg::TEXT_LEN_MAX)) ?
                  nlp_pkg::CH_NUL : in_ch.char_in;
  assign hex_d  = nlp_pkg::hex_value(c_eff);
  assign hex_ok = (hex_d != nlp_pkg::NOT_HEX);

  // Shift-add of the magnitude by the radix in force, wide enough to see overflow
  assign mag_ext = {{(nlp_pkg::MAC_W-nlp_pkg::VALUE_W){1'b0}}, mag_r};
  always_comb begin
    case (radix_r)
      nlp_pkg::RDX_2:  mac = (mag_ext << 1);
      nlp_pkg::RDX_8:  mac = (mag_ext << 3);
      nlp_pkg::RDX_10: mac = (mag_ext << 3) + (mag_ext << 1);
      nlp_pkg::RDX_16: mac = (mag_ext << 4);
      default:         mac = (mag_ext << 3) + (mag_ext << 1);
    endcase
    mac = mac + nlp_pkg::MAC_W'(hex_d);
  end
  assign mac_ovf  = |mac[nlp_pkg::MAC_W-1:nlp_pkg::VALUE_W-1];
  assign digit_ok = (hex_d < nlp_pkg::radix_value(radix_r));

  assign fd_char   = in_ch.start_req ? in_ch.char_in : c_eff;
  assign fd_base   = in_ch.start_req ? '0 : count_r;
  assign fd_is_dec = (fd_char >= nlp_pkg::CH_0) && (fd_char <= nlp_pkg::CH_9);

  // Prefix letter held after a leading zero
  always_comb begin
    pfx_known = 1'b1;
    case (held_r)
      nlp_pkg::CH_LX, nlp_pkg::CH_UX: pfx_radix = nlp_pkg::RDX_16;
      nlp_pkg::CH_LO, nlp_pkg::CH_UO: pfx_radix = nlp_pkg::RDX_8;
      nlp_pkg::CH_LT, nlp_pkg::CH_UT: pfx_radix = nlp_pkg::RDX_2;
      default: begin
        pfx_radix = nlp_pkg::RDX_10;
        pfx_known = 1'b0;
      end
    endcase
  end
  assign pfx_room = ({1'b0, count_r} + (nlp_pkg::COUNT_W+1)'(2)) <=
                    (nlp_pkg::COUNT_W+1)'(nlp_pkg::TEXT_LEN_MAX);

  // Result of closing the literal with what has been gathered so far
  always_comb begin
    fin_res.status   = nlp_pkg::ST_OK;
    fin_res.value    = neg_r ? -mag_r : mag_r;
    fin_res.consumed = count_r;
  end

  // Next parser state and the result this character causes
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    radix_nxt = radix_r;
    mag_nxt   = mag_r;
    count_nxt = count_r;
    held_nxt  = held_r;
    res_vld   = 1'b0;
    res       = '0;

    if (in_ch.start_req || (phase_r == nlp_pkg::PH_SIGN)) begin
      if (in_ch.start_req) begin
        neg_nxt   = 1'b0;
        radix_nxt = nlp_pkg::RDX_10;
        mag_nxt   = '0;
        count_nxt = '0;
        held_nxt  = '0;
      end
      if (in_ch.start_req &&
          ((in_ch.char_in == nlp_pkg::CH_PLUS) || (in_ch.char_in == nlp_pkg::CH_MINUS))) begin
        // open with a sign
        neg_nxt   = (in_ch.char_in == nlp_pkg::CH_MINUS);
        count_nxt = nlp_pkg::COUNT_W'(1);
        phase_nxt = nlp_pkg::PH_SIGN;
      end else if (!fd_is_dec) begin
        // not a number
        res_vld       = 1'b1;
        res.status    = nlp_pkg::ST_NAN;
        phase_nxt     = nlp_pkg::PH_IDLE;
      end else begin
        count_nxt = fd_base + nlp_pkg::COUNT_W'(1);
        if (fd_char == nlp_pkg::CH_0) begin
          radix_nxt = nlp_pkg::RDX_8;
          mag_nxt   = '0;
          phase_nxt = nlp_pkg::PH_ZERO;
        end else begin
          radix_nxt = nlp_pkg::RDX_10;
          mag_nxt   = nlp_pkg::VALUE_W'(fd_char - nlp_pkg::CH_0);
          phase_nxt = nlp_pkg::PH_DIGITS;
        end
      end
    end else begin
      case (phase_r)
        nlp_pkg::PH_ZERO, nlp_pkg::PH_DIGITS: begin
          if ((phase_r == nlp_pkg::PH_ZERO) && !hex_ok && (c_eff != nlp_pkg::CH_NUL)) begin
            // hold a possible prefix letter
            held_nxt  = c_eff;
            phase_nxt = nlp_pkg::PH_PREFIX;
          end else if (!digit_ok) begin
            res_vld   = 1'b1;
            res       = fin_res;
            phase_nxt = nlp_pkg::PH_IDLE;
          end else if (mac_ovf) begin
            res_vld    = 1'b1;
            res.status = nlp_pkg::ST_OVF;
            phase_nxt  = nlp_pkg::PH_IDLE;
          end else begin
            mag_nxt   = mac[nlp_pkg::VALUE_W-1:0];
            count_nxt = count_r + nlp_pkg::COUNT_W'(1);
            phase_nxt = nlp_pkg::PH_DIGITS;
          end
        end
        nlp_pkg::PH_PREFIX: begin
          if (hex_ok && pfx_known && pfx_room &&
              (hex_d < nlp_pkg::radix_value(pfx_radix))) begin
            // count the prefix letter and its first digit
            radix_nxt = pfx_radix;
            mag_nxt   = nlp_pkg::VALUE_W'(hex_d);
            count_nxt = count_r + nlp_pkg::COUNT_W'(2);
            phase_nxt = nlp_pkg::PH_DIGITS;
          end else begin
            res_vld   = 1'b1;
            res       = fin_res;
            phase_nxt = nlp_pkg::PH_IDLE;
          end
        end
        nlp_pkg::PH_IDLE: begin
          phase_nxt = nlp_pkg::PH_IDLE;
        end
        default: begin
          phase_nxt = nlp_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Advance the result buffer: refill from skid on drain, park in skid on stall
  always_comb begin
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r;
    skid_nxt     = skid_r;
    skid_vld_nxt = skid_vld_r;
    if (!out_vld_r || out_ch.ready) begin
      if (skid_vld_r) begin
        out_nxt      = skid_r;
        out_vld_nxt  = 1'b1;
        skid_nxt     = res;
        skid_vld_nxt = in_acc && res_vld;
      end else begin
        out_nxt     = res;
        out_vld_nxt = in_acc && res_vld;
      end
    end else if (in_acc && res_vld) begin
      skid_nxt     = res;
      skid_vld_nxt = 1'b1;
    end
  end

  // Update parser state on an accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= nlp_pkg::PH_IDLE;
      neg_r   <= 1'b0;
      radix_r <= nlp_pkg::RDX_10;
      mag_r   <= '0;
      count_r <= '0;
      held_r  <= '0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      radix_r <= radix_nxt;
      mag_r   <= mag_nxt;
      count_r <= count_nxt;
      held_r  <= held_nxt;
    end
  end

  // Result buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // Result buffer payload
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.status   = out_r.status;
  assign out_ch.value    = out_r.value;
  assign out_ch.consumed = out_r.consumed;

  // Skid entry is only ever filled behind a waiting main entry
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry valid while main entry empty");

  // A failed literal carries neither value nor length
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_r.status != nlp_pkg::ST_OK)) |->
      ((out_r.value == '0) && (out_r.consumed == '0)))
    else $error("failed literal with nonzero value or length");

  // Character count never passes the text length limit
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= nlp_pkg::COUNT_W'(nlp_pkg::TEXT_LEN_MAX))
    else $error("character count beyond text length limit");

  // A parked result moves to the port once the main entry drains
  a_skid_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && out_ch.ready) |=> (out_vld_r && (out_r == $past(skid_r))))
    else $error("skid entry not moved to main entry on drain");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking bench for number_literal_parser_core: streams literals, noise and
// long runs of characters, predicts every result and compares it field by field.
// Depends on nlp_pkg (hdl/nlp_pkg.sv) and the channels in hdl/nlp_channels.sv.
`default_nettype none

module tb_top;
  import nlp_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int ITEMS_PER_PHASE = 500;
  localparam int LONG_RUN = TEXT_LEN_MAX + 4;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2c;
  localparam logic [CHAR_W-1:0] CH_DOT = 8'h2e;
  localparam logic [CHAR_W-1:0] CH_LD = 8'h64;
  localparam logic [CHAR_W-1:0] CH_UD = 8'h44;
  localparam logic [CHAR_W-1:0] CH_LG = 8'h67;
  localparam logic [CHAR_W-1:0] CH_LQ = 8'h71;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;

  // Tracks the literal in progress and holds the results it must give, oldest first
  class literal_book;
    localparam int NO_DIGIT = 99;
    localparam logic [VALUE_W-1:0] MAG_MAX = 64'h7fff_ffff_ffff_ffff;

    phase_t ph;
    bit neg;
    int unsigned rdx;
    logic [VALUE_W-1:0] mag;
    int unsigned cnt;
    logic [CHAR_W-1:0] held;
    result_t due[$];
    int errors;

    function new();
      ph = PH_IDLE;
      neg = 1'b0;
      rdx = 10;
      mag = '0;
      cnt = 0;
      held = '0;
      errors = 0;
    endfunction

    function int unsigned digit_of(logic [CHAR_W-1:0] c);
      if (c >= CH_0 && c <= CH_9) return 32'(c - CH_0);
      if (c >= CH_LA && c <= CH_LF) return 32'(c - CH_LA) + 10;
      if (c >= CH_UA && c <= CH_UF) return 32'(c - CH_UA) + 10;
      return NO_DIGIT;
    endfunction

    function int outstanding();
      return due.size();
    endfunction

    function void emit(status_t st, logic [VALUE_W-1:0] v, int unsigned n);
      result_t r;
      r.status = st;
      r.value = v;
      r.consumed = COUNT_W'(n);
      due.push_back(r);
      ph = PH_IDLE;
    endfunction

    // Close a literal normally: apply the sign to the magnitude
    function void close_ok();
      emit(ST_OK, neg ? (64'd0 - mag) : mag, cnt);
    endfunction

    function void lead_digit(logic [CHAR_W-1:0] c);
      if (c < CH_0 || c > CH_9) begin
        emit(ST_NAN, '0, 0);
        return;
      end
      cnt++;
      if (c == CH_0) begin
        rdx = 8;
        mag = '0;
        ph = PH_ZERO;
      end else begin
        rdx = 10;
        mag = 64'(c - CH_0);
        ph = PH_DIGITS;
      end
    endfunction

    // Shift in one digit; close on a non-digit, flag overflow past 2^63-1
    function void accumulate(logic [CHAR_W-1:0] c);
      int unsigned d;
      logic [VALUE_W-1:0] lim;
      d = digit_of(c);
      if (d >= rdx) begin
        close_ok();
        return;
      end
      lim = (MAG_MAX - 64'(d)) / 64'(rdx);
      if (mag > lim) begin
        emit(ST_OVF, '0, 0);
        return;
      end
      mag = mag * 64'(rdx) + 64'(d);
      cnt++;
      ph = PH_DIGITS;
    endfunction

    // Note one accepted character; returns 1 unless the block ignores it
    function bit take_char(logic [CHAR_W-1:0] c, bit s);
      logic [CHAR_W-1:0] ch;
      int unsigned base;
      ch = c;
      if (s) begin
        neg = 1'b0;
        rdx = 10;
        mag = '0;
        cnt = 0;
        held = '0;
        if (ch == CH_PLUS || ch == CH_MINUS) begin
          neg = (ch == CH_MINUS);
          cnt = 1;
          ph = PH_SIGN;
        end else begin
          lead_digit(ch);
        end
        return 1'b1;
      end
      if (ph == PH_IDLE) return 1'b0;
      // treat the character past the length limit as end of text
      if (cnt >= TEXT_LEN_MAX) ch = CH_NUL;
      case (ph)
        PH_SIGN: lead_digit(ch);
        PH_ZERO: begin
          if (digit_of(ch) != NO_DIGIT) accumulate(ch);
          else if (ch == CH_NUL) close_ok();
          else begin
            held = ch;
            ph = PH_PREFIX;
          end
        end
        PH_PREFIX: begin
          if (digit_of(ch) == NO_DIGIT) begin
            close_ok();
          end else begin
            case (held)
              CH_LX, CH_UX: base = 16;
              CH_LO, CH_UO: base = 8;
              CH_LT, CH_UT: base = 2;
              default:      base = 0;
            endcase
            if (base == 0 || digit_of(ch) >= base || cnt + 2 > TEXT_LEN_MAX) begin
              close_ok();
            end else begin
              cnt++;
              rdx = base;
              accumulate(ch);
            end
          end
        end
        PH_DIGITS: accumulate(ch);
        default: ph = PH_IDLE;
      endcase
      return 1'b1;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(status_t st, logic signed [VALUE_W-1:0] v,
                      logic [COUNT_W-1:0] n);
      result_t e;
      if (due.size() == 0) begin
        report($sformatf("unexpected result status %0d value %0d consumed %0d",
                         st, v, n));
        return;
      end
      e = due.pop_front();
      if (st !== e.status)
        report($sformatf("status %0d, expected %0d", st, e.status));
      if (v !== e.value)
        report($sformatf("value %0d, expected %0d", v, e.value));
      if (n !== e.consumed)
        report($sformatf("consumed %0d, expected %0d", n, e.consumed));
    endtask

    task close_out();
      if (due.size() != 0)
        report($sformatf("%0d results never arrived", due.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  nlp_in_if in_ch ();
  nlp_out_if out_ch ();
  literal_book book = new();
  int idle_pct;
  int stall_pct;
  int cycles;
  int used_chars;
  bit fresh;

  number_literal_parser_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the result channel at random and check every result transaction
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    out_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
    if (rst_n && out_ch.valid && out_ch.ready)
      book.check_result(out_ch.status, out_ch.value, out_ch.consumed);
  end

  // Offer one character, with random idle cycles first; hold it until taken
  task automatic send_char(input logic [CHAR_W-1:0] c, input bit s);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_in <= c;
    in_ch.start_req <= s;
    do @(posedge clk); while (!in_ch.ready);
    if (book.take_char(c, s)) used_chars++;
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] c);
    send_char(c, fresh);
    fresh = 1'b0;
  endtask

  task automatic send_literal(input string body, input int stop);
    fresh = 1'b1;
    for (int i = 0; i < body.len(); i++) put_char(body[i]);
    if (stop >= 0) put_char(stop[CHAR_W-1:0]);
    fresh = 1'b0;
  endtask

  // Drop valid and hold off until every expected result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (book.outstanding() != 0);
  endtask

  function automatic logic [CHAR_W-1:0] hex_char(input int unsigned v, input bit up);
    if (v < 10) return CH_0 + CHAR_W'(v);
    return (up ? CH_UA : CH_LA) + CHAR_W'(v - 10);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_stop();
    case ($urandom_range(3))
      0:       return CH_NUL;
      1:       return CH_SPACE;
      2:       return CH_COMMA;
      default: return CHAR_W'($urandom_range(255));
    endcase
  endfunction

  // One random literal: mostly well-formed bodies, some noise and broken prefixes
  task automatic random_literal();
    string top_digits = "922337203685477580";
    int kind;
    int n;
    kind = $urandom_range(99);
    fresh = 1'b1;
    if (kind < 10) begin
      n = $urandom_range(1, 8);
      repeat (n) send_char(CHAR_W'($urandom_range(255)), $urandom_range(3) == 0);
      fresh = 1'b0;
      return;
    end
    case ($urandom_range(3))
      0:       put_char(CH_PLUS);
      1:       put_char(CH_MINUS);
      default: ;
    endcase
    if (kind < 40) begin
      // decimal, sometimes right at the overflow boundary
      if ($urandom_range(3) == 0) begin
        for (int i = 0; i < top_digits.len(); i++) put_char(top_digits[i]);
        n = $urandom_range(0, 2);
      end else begin
        put_char(CH_0 + CHAR_W'($urandom_range(1, 9)));
        n = $urandom_range(1) ? $urandom_range(0, 5) : $urandom_range(15, 21);
      end
      repeat (n) put_char(CH_0 + CHAR_W'($urandom_range(9)));
    end else if (kind < 55) begin
      put_char(CH_0);
      put_char($urandom_range(1) ? CH_LX : CH_UX);
      n = $urandom_range(1, 17);
      repeat (n) put_char(hex_char($urandom_range(15), $urandom_range(1) == 1));
    end else if (kind < 65) begin
      put_char(CH_0);
      put_char($urandom_range(1) ? CH_LO : CH_UO);
      n = $urandom_range(1, 23);
      repeat (n) put_char(CH_0 + CHAR_W'($urandom_range(7)));
    end else if (kind < 75) begin
      put_char(CH_0);
      put_char($urandom_range(1) ? CH_LT : CH_UT);
      n = $urandom_range(1, 66);
      repeat (n) put_char(($urandom_range(3) != 0) ? CH_0 + 8'd1 : CH_0);
    end else if (kind < 83) begin
      put_char(CH_0);
      n = $urandom_range(0, 23);
      repeat (n) put_char(CH_0 + CHAR_W'($urandom_range(7)));
    end else if (kind < 91) begin
      // broken start or questionable prefix letter
      if ($urandom_range(3) == 0) begin
        put_char(CHAR_W'($urandom_range(CH_COLON, 255)));
      end else begin
        put_char(CH_0);
        case ($urandom_range(5))
          0:       put_char(CH_LD);
          1:       put_char(CH_UD);
          2:       put_char(CH_LQ);
          3:       put_char(CH_DOT);
          default: put_char(CHAR_W'($urandom_range(1, 255)));
        endcase
        if ($urandom_range(1)) put_char(CHAR_W'($urandom_range(255)));
        else put_char(hex_char($urandom_range(15), $urandom_range(1) == 1));
      end
    end else begin
      // digit outside the selected radix right after the prefix
      put_char(CH_0);
      case ($urandom_range(2))
        0: begin
          put_char(CH_LT);
          put_char(CH_0 + CHAR_W'($urandom_range(2, 9)));
        end
        1: begin
          put_char(CH_UO);
          put_char(CH_0 + CHAR_W'($urandom_range(8, 9)));
        end
        default: begin
          put_char(CH_LX);
          put_char(CH_LG);
        end
      endcase
    end
    // leave some literals open so the next start abandons them
    if ($urandom_range(4) != 0) put_char(pick_stop());
    fresh = 1'b0;
  endtask

  initial begin
    int goal;
    in_ch.valid = 1'b0;
    in_ch.char_in = '0;
    in_ch.start_req = 1'b0;
    out_ch.ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    cycles = 0;
    used_chars = 0;
    fresh = 1'b0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // idle characters before any literal: ignored
    send_char(8'hff, 1'b0);
    send_char(CH_9, 1'b0);
    send_literal("0", CH_NUL);
    send_literal("-0", CH_SPACE);
    send_literal("+7", CH_NUL);
    send_literal("-9223372036854775807", CH_NUL);
    send_literal("-9223372036854775808", CH_NUL);
    send_literal("9223372036854775807", CH_SPACE);
    send_literal("92233720368547758070", CH_SPACE);
    send_literal("0x7fffffffffffffff", CH_COMMA);
    send_literal("0X8000000000000000", CH_NUL);
    send_literal("0xAbCdEf", CH_SPACE);
    send_literal("0o17", CH_SPACE);
    send_literal("0O8", CH_SPACE);
    send_literal("0t101", CH_NUL);
    send_literal("0T2", CH_NUL);
    send_literal("0d5", CH_SPACE);
    send_literal("0q5", CH_SPACE);
    send_literal("0xg", CH_SPACE);
    send_literal("0x", CH_NUL);
    send_literal("017", CH_SPACE);
    send_literal("09", CH_SPACE);
    send_literal("abc", CH_SPACE);
    send_literal("-x", CH_SPACE);
    send_literal("+", CH_NUL);
    send_literal("12", -1);
    send_literal("5", 8'h80);
    send_char(8'hff, 1'b1);

    // run of zeros past the text length limit
    fresh = 1'b1;
    repeat (LONG_RUN) put_char(CH_0);
    put_char(CH_SPACE);
    drain_results();

    // random literals under each idling pattern, draining between phases
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 78; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      goal = used_chars + ITEMS_PER_PHASE;
      while (used_chars < goal) random_literal();
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    book.close_out();
    if (book.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
